/* design/event_trace_ring_buffer_defines.svh */
// Assertion macros for the event trace ring buffer.
// Used by the control module; expects clk and arst_n in scope.
`ifndef EVENT_TRACE_RING_BUFFER_DEFINES_SVH
`define EVENT_TRACE_RING_BUFFER_DEFINES_SVH

// Check outside reset only.
`define ETRB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every edge, reset included.
`define ETRB_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/etrb_pkg.sv */
// Shared types and constants of the event trace ring buffer.
// No dependencies; used by event_trace_ring_buffer, etrb_mem and etrb_ctrl.
`default_nettype none

package etrb_pkg;

	localparam int unsigned DEF_CAPACITY = 64;
	localparam int unsigned PEND_W       = 7;
	localparam logic [15:0] SAT16        = 16'hFFFF;
	localparam logic [7:0]  NODE_RST     = 8'd0;
	localparam logic [7:0]  RECOV_RST    = 8'd1;

	typedef enum logic [2:0] {
		ACT_STATE = 3'd0,
		ACT_ACTION = 3'd1,
		ACT_EVENT = 3'd2,
		ACT_IO = 3'd3,
		ACT_READ = 3'd4,
		ACT_POP = 3'd5,
		ACT_CLEAR = 3'd6,
		ACT_RTSET = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		MOD_STATE = 2'd0,
		MOD_ACTION = 2'd1,
		MOD_EVENT = 2'd2,
		MOD_IO = 2'd3
	} mod_t;

	localparam logic [1:0] LVL_INFO = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;

	typedef enum logic {
		CFG_NODE_ID = 1'b0,
		CFG_RECOVERED = 1'b1
	} cfg_reg_t;

	// One stored trace record: time/sequence word and body.
	typedef struct packed {
		logic [31:0] tick;
		logic [31:0] seq;
		logic [7:0]  node;
		logic [1:0]  level;
		logic [1:0]  module_code;
		logic [7:0]  event_code;
		logic [15:0] arg0;
		logic [15:0] arg1;
	} rec_t;

	// Accepted input beat.
	typedef struct packed {
		act_t        action;
		logic [7:0]  code;
		logic [7:0]  prior_state;
		logic [31:0] elapsed_time;
		logic [31:0] arg_wide0;
		logic [31:0] arg_wide1;
		logic [7:0]  in_low_byte;
		logic [7:0]  in_high_byte;
		logic [7:0]  out_low_byte;
		logic [7:0]  out_high_byte;
		logic        enable;
		logic [31:0] now_ms;
	} req_t;

	// Status that travels with each result beat.
	typedef struct packed {
		logic              record_valid;
		logic [PEND_W-1:0] pending;
		logic [31:0]       drop_total;
		logic [31:0]       realtime_drop_total;
	} stat_t;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (|v[31:16]) ? SAT16 : v[15:0];
	endfunction

endpackage

`default_nettype wire

/* design/etrb_in_if.sv */
// Input channel of the event trace ring buffer: valid/ready plus command fields.
// No dependencies.
`default_nettype none

interface etrb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  code;
	logic [7:0]  prior_state;
	logic [31:0] elapsed_time;
	logic [31:0] arg_wide0;
	logic [31:0] arg_wide1;
	logic [7:0]  in_low_byte;
	logic [7:0]  in_high_byte;
	logic [7:0]  out_low_byte;
	logic [7:0]  out_high_byte;
	logic        enable;
	logic [31:0] now_ms;

	modport source (
		output valid, action, code, prior_state, elapsed_time, arg_wide0, arg_wide1,
		output in_low_byte, in_high_byte, out_low_byte, out_high_byte, enable, now_ms,
		input ready
	);
	modport sink (
		input valid, action, code, prior_state, elapsed_time, arg_wide0, arg_wide1,
		input in_low_byte, in_high_byte, out_low_byte, out_high_byte, enable, now_ms,
		output ready
	);
endinterface

`default_nettype wire

/* design/etrb_out_if.sv */
// Result channel of the event trace ring buffer: valid/ready plus record fields.
// No dependencies.
`default_nettype none

interface etrb_out_if;
	logic        valid;
	logic        ready;
	logic        record_valid;
	logic [31:0] rec_seq;
	logic [31:0] rec_tick;
	logic [7:0]  rec_node;
	logic [1:0]  rec_level;
	logic [1:0]  rec_module;
	logic [7:0]  rec_event;
	logic [15:0] rec_arg0;
	logic [15:0] rec_arg1;
	logic [6:0]  pending;
	logic [31:0] drop_total;
	logic [31:0] realtime_drop_total;

	modport source (
		output valid, record_valid, rec_seq, rec_tick, rec_node, rec_level, rec_module,
		output rec_event, rec_arg0, rec_arg1, pending, drop_total, realtime_drop_total,
		input ready
	);
	modport sink (
		input valid, record_valid, rec_seq, rec_tick, rec_node, rec_level, rec_module,
		input rec_event, rec_arg0, rec_arg1, pending, drop_total, realtime_drop_total,
		output ready
	);
endinterface

`default_nettype wire

/* design/event_trace_ring_buffer.sv */
// Event trace ring buffer: input and result channels, write-only config port.
//
// Channels: in_ch takes one command beat (push of four kinds, read, realtime
// pop, clear, set realtime); out_ch returns exactly one result beat for every
// command beat, in order. Results of pushes, clear and set realtime carry
// record_valid low with all record fields zero, plus the pending count and
// both drop totals as they stand after the command.
// The command's status and store read are registered in stage 1, then loaded
// into the out_ch register once that register is free, where out_ch can take it.
// Throughput: one command per cycle unless out_ch stalls; a push uses the single
// store write port once, a read or pop that returns a record the single read port.
// Reset: cursors, fill counts, sequence and drop counters clear at once;
// node_id resets to 0, recovered_event_code to 1. Store contents are
// undefined, but no cursor can reach an entry that was never written.
// Stall: while out_ch is held, the finished result waits in the output
// register and one more command may still be taken; then in_ch.ready drops
// and the read data and status hold until the output frees up.
// Depends on etrb_pkg, etrb_in_if, etrb_out_if, etrb_mem and etrb_ctrl.
`default_nettype none

module event_trace_ring_buffer #(
	parameter int unsigned CAPACITY = etrb_pkg::DEF_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	etrb_in_if.sink          in_ch,
	etrb_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [7:0]  cfg_data
);

	localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	etrb_pkg::req_t   req;
	etrb_pkg::rec_t   wdata, rdata;
	etrb_pkg::stat_t  stat, stat_s1;
	logic             valid_s1;
	logic             out_valid_q;
	etrb_pkg::stat_t  out_stat_q;
	etrb_pkg::rec_t   out_rec_q;
	logic             out_free, accept;
	logic             mem_we, mem_re;
	logic [PTR_W-1:0] mem_waddr, mem_raddr;

	// Pack the command beat.
	assign req.action = etrb_pkg::act_t'(in_ch.action);
	assign req.code = in_ch.code;
	assign req.prior_state = in_ch.prior_state;
	assign req.elapsed_time = in_ch.elapsed_time;
	assign req.arg_wide0 = in_ch.arg_wide0;
	assign req.arg_wide1 = in_ch.arg_wide1;
	assign req.in_low_byte = in_ch.in_low_byte;
	assign req.in_high_byte = in_ch.in_high_byte;
	assign req.out_low_byte = in_ch.out_low_byte;
	assign req.out_high_byte = in_ch.out_high_byte;
	assign req.enable = in_ch.enable;
	assign req.now_ms = in_ch.now_ms;

	// The output register frees up when empty or when its beat is taken.
	// Stage 1 moves only into a free output register, so take a new command
	// only when stage 1 is empty or about to move.
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || out_free;
	assign accept = in_ch.valid && in_ch.ready;

	etrb_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.accept(accept),
		.req(req),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.stat(stat)
	);

	etrb_mem #(
		.CAPACITY(CAPACITY)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	// Stage 1: status of the accepted command, aligned with the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= stat;
		end
	end

	// Output register: load when free; zero the record when none returned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_stat_q <= stat_s1;
			out_rec_q <= stat_s1.record_valid ? rdata : '0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.record_valid = out_stat_q.record_valid;
	assign out_ch.rec_seq = out_rec_q.seq;
	assign out_ch.rec_tick = out_rec_q.tick;
	assign out_ch.rec_node = out_rec_q.node;
	assign out_ch.rec_level = out_rec_q.level;
	assign out_ch.rec_module = out_rec_q.module_code;
	assign out_ch.rec_event = out_rec_q.event_code;
	assign out_ch.rec_arg0 = out_rec_q.arg0;
	assign out_ch.rec_arg1 = out_rec_q.arg1;
	assign out_ch.pending = out_stat_q.pending;
	assign out_ch.drop_total = out_stat_q.drop_total;
	assign out_ch.realtime_drop_total = out_stat_q.realtime_drop_total;

endmodule

`default_nettype wire

/* design/etrb_mem.sv */
// Record store: one write port, one registered read port.
// Depends on etrb_pkg for the record type.
`default_nettype none

module etrb_mem #(
	parameter int unsigned CAPACITY = etrb_pkg::DEF_CAPACITY,
	localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [PTR_W-1:0] waddr,
	input  wire etrb_pkg::rec_t  wdata,
	input  wire logic            re,
	input  wire logic [PTR_W-1:0] raddr,
	output etrb_pkg::rec_t       rdata
);

	etrb_pkg::rec_t store [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= store[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/etrb_ctrl.sv */
// Cursor, fill and counter control; builds records and drives the store ports.
// Depends on etrb_pkg and event_trace_ring_buffer_defines.svh.
`default_nettype none
`include "event_trace_ring_buffer_defines.svh"

module etrb_ctrl #(
	parameter int unsigned CAPACITY = etrb_pkg::DEF_CAPACITY,
	localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned FILL_W = $clog2(CAPACITY + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_idx,
	input  wire logic [7:0]       cfg_data,
	input  wire logic             accept,
	input  wire etrb_pkg::req_t   req,
	output logic                  mem_we,
	output logic [PTR_W-1:0]      mem_waddr,
	output etrb_pkg::rec_t        mem_wdata,
	output logic                  mem_re,
	output logic [PTR_W-1:0]      mem_raddr,
	output etrb_pkg::stat_t       stat
);

	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(CAPACITY - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

	logic [PTR_W-1:0]  write_ptr_q, read_ptr_q, live_ptr_q;
	logic [PTR_W-1:0]  write_ptr_d, read_ptr_d, live_ptr_d;
	logic [FILL_W-1:0] read_fill_q, live_fill_q, read_fill_d, live_fill_d;
	logic              live_on_q, live_on_d;
	logic [31:0]       seq_q, seq_d, drop_q, drop_d, live_drop_q, live_drop_d;
	logic [7:0]        node_id_q, recov_q;
	logic              rec_valid;
	logic              is_push;

	function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		mem_wdata = '0;
		mem_wdata.tick = req.now_ms;
		mem_wdata.seq = seq_q + 32'd1;
		mem_wdata.node = node_id_q;
		mem_wdata.level = etrb_pkg::LVL_INFO;
		mem_wdata.event_code = req.code;
		unique case (req.action)
			etrb_pkg::ACT_STATE: begin
				mem_wdata.module_code = etrb_pkg::MOD_STATE;
				mem_wdata.arg0 = {8'd0, req.prior_state};
				mem_wdata.arg1 = etrb_pkg::sat16(req.elapsed_time);
			end
			etrb_pkg::ACT_ACTION: begin
				mem_wdata.module_code = etrb_pkg::MOD_ACTION;
				mem_wdata.arg0 = etrb_pkg::sat16(req.elapsed_time);
				mem_wdata.arg1 = req.arg_wide1[15:0];
			end
			etrb_pkg::ACT_EVENT: begin
				mem_wdata.module_code = etrb_pkg::MOD_EVENT;
				mem_wdata.level = (req.code == recov_q) ? etrb_pkg::LVL_INFO
					: etrb_pkg::LVL_WARN;
				mem_wdata.arg0 = etrb_pkg::sat16(req.arg_wide0);
				mem_wdata.arg1 = etrb_pkg::sat16(req.arg_wide1);
			end
			default: begin
				mem_wdata.module_code = etrb_pkg::MOD_IO;
				mem_wdata.event_code = 8'd0;
				mem_wdata.arg0 = {req.in_low_byte, req.in_high_byte};
				mem_wdata.arg1 = {req.out_low_byte, req.out_high_byte};
			end
		endcase
	end

	assign is_push = (req.action == etrb_pkg::ACT_STATE) || (req.action == etrb_pkg::ACT_ACTION)
		|| (req.action == etrb_pkg::ACT_EVENT) || (req.action == etrb_pkg::ACT_IO);
	assign mem_waddr = write_ptr_q;

	always_comb begin
		write_ptr_d = write_ptr_q;
		read_ptr_d = read_ptr_q;
		read_fill_d = read_fill_q;
		live_ptr_d = live_ptr_q;
		live_fill_d = live_fill_q;
		live_on_d = live_on_q;
		seq_d = seq_q;
		drop_d = drop_q;
		live_drop_d = live_drop_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_raddr = read_ptr_q;
		rec_valid = 1'b0;
		unique case (req.action) inside
			etrb_pkg::ACT_STATE, etrb_pkg::ACT_ACTION, etrb_pkg::ACT_EVENT,
			etrb_pkg::ACT_IO: begin
				mem_we = accept;
				seq_d = seq_q + 32'd1;
				write_ptr_d = step_ptr(write_ptr_q);
				if (read_fill_q >= FILL_MAX) begin
					read_ptr_d = step_ptr(read_ptr_q);
					drop_d = drop_q + 32'd1;
				end else begin
					read_fill_d = read_fill_q + 1'b1;
				end
				if (live_on_q) begin
					if (live_fill_q >= FILL_MAX) begin
						live_ptr_d = step_ptr(live_ptr_q);
						live_drop_d = live_drop_q + 32'd1;
					end else begin
						live_fill_d = live_fill_q + 1'b1;
					end
				end
			end
			etrb_pkg::ACT_READ: begin
				if (read_fill_q != '0) begin
					rec_valid = 1'b1;
					mem_re = accept;
					read_ptr_d = step_ptr(read_ptr_q);
					read_fill_d = read_fill_q - 1'b1;
				end
			end
			etrb_pkg::ACT_POP: begin
				mem_raddr = live_ptr_q;
				if (live_on_q && (live_fill_q != '0)) begin
					rec_valid = 1'b1;
					mem_re = accept;
					live_ptr_d = step_ptr(live_ptr_q);
					live_fill_d = live_fill_q - 1'b1;
				end
			end
			etrb_pkg::ACT_CLEAR: begin
				write_ptr_d = '0;
				read_ptr_d = '0;
				read_fill_d = '0;
				live_ptr_d = '0;
				live_fill_d = '0;
				drop_d = '0;
				live_drop_d = '0;
			end
			default: begin
				live_on_d = req.enable;
				live_ptr_d = write_ptr_q;
				live_fill_d = '0;
			end
		endcase
	end

	assign stat.record_valid = rec_valid;
	assign stat.pending = etrb_pkg::PEND_W'(read_fill_d);
	assign stat.drop_total = drop_d;
	assign stat.realtime_drop_total = live_drop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_ptr_q <= '0;
			read_ptr_q <= '0;
			read_fill_q <= '0;
			live_ptr_q <= '0;
			live_fill_q <= '0;
			live_on_q <= 1'b0;
			seq_q <= '0;
			drop_q <= '0;
			live_drop_q <= '0;
		end else if (accept) begin
			write_ptr_q <= write_ptr_d;
			read_ptr_q <= read_ptr_d;
			read_fill_q <= read_fill_d;
			live_ptr_q <= live_ptr_d;
			live_fill_q <= live_fill_d;
			live_on_q <= live_on_d;
			seq_q <= seq_d;
			drop_q <= drop_d;
			live_drop_q <= live_drop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= etrb_pkg::NODE_RST;
			recov_q <= etrb_pkg::RECOV_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				etrb_pkg::CFG_NODE_ID: node_id_q <= cfg_data;
				default: recov_q <= cfg_data;
			endcase
		end
	end

	`ETRB_ASSERT(a_fill_bound, (read_fill_q <= FILL_MAX) && (live_fill_q <= FILL_MAX), "fill overflow")
	`ETRB_ASSERT(a_live_off_empty, (!live_on_q |-> live_fill_q == '0), "realtime fill while off")
	`ETRB_ASSERT(a_seq_step, (accept && is_push |=> seq_q == $past(seq_q) + 32'd1), "push did not advance sequence")

endmodule

`default_nettype wire

/* sim/trace_checker.sv */
// Checker for the event trace ring buffer: mirrors the command/result channels and
// the config port, predicts each result beat and compares it field by field.
// Depends on etrb_pkg, etrb_in_if and etrb_out_if.
module trace_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	etrb_in_if              in_mon,
	etrb_out_if             out_mon,
	input  wire logic       cfg_we,
	input  wire logic       cfg_idx,
	input  wire logic [7:0] cfg_data,
	output int unsigned     mismatches,
	output int unsigned     awaiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import etrb_pkg::*;

	localparam int unsigned DEPTH = DEF_CAPACITY;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	typedef struct packed {
		logic              record_valid;
		rec_t              rec;
		logic [PEND_W-1:0] pending;
		logic [31:0]       drops;
		logic [31:0]       rt_drops;
	} reply_t;

	rec_t             trace_mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] rt_ptr;
	int unsigned      rd_fill;
	int unsigned      rt_fill;
	logic             rt_on;
	logic [31:0]      seq_ctr;
	logic [31:0]      drop_ctr;
	logic [31:0]      rt_drop_ctr;
	logic [7:0]       node_id;
	logic [7:0]       recovered_code;
	reply_t           due_replies [$];

	function automatic logic [15:0] clip16(input logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

	// Store one record; a full ring drops its oldest entry for each cursor.
	task automatic log_record(input logic [1:0] lvl, input mod_t kind, input logic [7:0] ev,
			input logic [15:0] a0, input logic [15:0] a1, input logic [31:0] now);
		rec_t r;
		seq_ctr       = seq_ctr + 32'd1;
		r.tick        = now;
		r.seq         = seq_ctr;
		r.node        = node_id;
		r.level       = lvl;
		r.module_code = kind;
		r.event_code  = ev;
		r.arg0        = a0;
		r.arg1        = a1;
		trace_mem[wr_ptr] = r;
		wr_ptr = wr_ptr + 1'b1;
		if (rd_fill >= DEPTH) begin
			rd_ptr   = rd_ptr + 1'b1;
			drop_ctr = drop_ctr + 32'd1;
		end else begin
			rd_fill++;
		end
		if (rt_on) begin
			if (rt_fill >= DEPTH) begin
				rt_ptr      = rt_ptr + 1'b1;
				rt_drop_ctr = rt_drop_ctr + 32'd1;
			end else begin
				rt_fill++;
			end
		end
	endtask

	task automatic predict_reply(input req_t c, output reply_t r);
		r = '0;
		case (c.action)
		ACT_STATE: begin
			log_record(LVL_INFO, MOD_STATE, c.code, {8'h00, c.prior_state},
				clip16(c.elapsed_time), c.now_ms);
		end
		ACT_ACTION: begin
			log_record(LVL_INFO, MOD_ACTION, c.code, clip16(c.elapsed_time),
				c.arg_wide1[15:0], c.now_ms);
		end
		ACT_EVENT: begin
			log_record((c.code == recovered_code) ? LVL_INFO : LVL_WARN, MOD_EVENT, c.code,
				clip16(c.arg_wide0), clip16(c.arg_wide1), c.now_ms);
		end
		ACT_IO: begin
			log_record(LVL_INFO, MOD_IO, 8'h00, {c.in_low_byte, c.in_high_byte},
				{c.out_low_byte, c.out_high_byte}, c.now_ms);
		end
		ACT_READ: begin
			if (rd_fill != 0) begin
				r.record_valid = 1'b1;
				r.rec          = trace_mem[rd_ptr];
				rd_ptr         = rd_ptr + 1'b1;
				rd_fill--;
			end
		end
		ACT_POP: begin
			if (rt_on && rt_fill != 0) begin
				r.record_valid = 1'b1;
				r.rec          = trace_mem[rt_ptr];
				rt_ptr         = rt_ptr + 1'b1;
				rt_fill--;
			end
		end
		ACT_CLEAR: begin
			// sequence counter and realtime enable survive a clear
			wr_ptr      = '0;
			rd_ptr      = '0;
			rd_fill     = 0;
			rt_ptr      = '0;
			rt_fill     = 0;
			drop_ctr    = '0;
			rt_drop_ctr = '0;
		end
		ACT_RTSET: begin
			rt_on   = c.enable;
			rt_ptr  = wr_ptr;
			rt_fill = 0;
		end
		endcase
		r.pending  = rd_fill[PEND_W-1:0];
		r.drops    = drop_ctr;
		r.rt_drops = rt_drop_ctr;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : watch
		req_t   cmd;
		reply_t want;
		if (!arst_n) begin
			wr_ptr         = '0;
			rd_ptr         = '0;
			rd_fill        = 0;
			rt_ptr         = '0;
			rt_fill        = 0;
			rt_on          = 1'b0;
			seq_ctr        = '0;
			drop_ctr       = '0;
			rt_drop_ctr    = '0;
			node_id        = NODE_RST;
			recovered_code = RECOV_RST;
			due_replies.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
				CFG_NODE_ID:   node_id = cfg_data;
				CFG_RECOVERED: recovered_code = cfg_data;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				cmd.action        = act_t'(in_mon.action);
				cmd.code          = in_mon.code;
				cmd.prior_state   = in_mon.prior_state;
				cmd.elapsed_time  = in_mon.elapsed_time;
				cmd.arg_wide0     = in_mon.arg_wide0;
				cmd.arg_wide1     = in_mon.arg_wide1;
				cmd.in_low_byte   = in_mon.in_low_byte;
				cmd.in_high_byte  = in_mon.in_high_byte;
				cmd.out_low_byte  = in_mon.out_low_byte;
				cmd.out_high_byte = in_mon.out_high_byte;
				cmd.enable        = in_mon.enable;
				cmd.now_ms        = in_mon.now_ms;
				predict_reply(cmd, want);
				due_replies.push_back(want);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (due_replies.size() == 0) begin
					$error("result beat arrived with no command outstanding");
					mismatches++;
				end else begin
					want = due_replies.pop_front();
					check_field("record_valid", want.record_valid, out_mon.record_valid);
					check_field("rec_seq", want.rec.seq, out_mon.rec_seq);
					check_field("rec_tick", want.rec.tick, out_mon.rec_tick);
					check_field("rec_node", want.rec.node, out_mon.rec_node);
					check_field("rec_level", want.rec.level, out_mon.rec_level);
					check_field("rec_module", want.rec.module_code, out_mon.rec_module);
					check_field("rec_event", want.rec.event_code, out_mon.rec_event);
					check_field("rec_arg0", want.rec.arg0, out_mon.rec_arg0);
					check_field("rec_arg1", want.rec.arg1, out_mon.rec_arg1);
					check_field("pending", want.pending, out_mon.pending);
					check_field("drop_total", want.drops, out_mon.drop_total);
					check_field("realtime_drop_total", want.rt_drops,
						out_mon.realtime_drop_total);
				end
			end
		end
		awaiting = due_replies.size();
	end

endmodule

/* sim/tb_top.sv */
// Top of the event trace ring buffer testbench: clock, reset, command and config
// stimulus, result back-pressure, watchdog and verdict.
// Depends on etrb_pkg, the channel interfaces, the ring buffer RTL and trace_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import etrb_pkg::*;

	localparam int unsigned PHASES           = 4;
	localparam int unsigned BEATS_PER_PHASE  = 150;
	localparam int unsigned FILL_BEATS       = 90;     // push-heavy head of each phase
	localparam int unsigned LONG_HOLD_CYCLES = 200;
	localparam int unsigned SETTLE_CYCLES    = 4;      // margin after the drain
	localparam int unsigned CYCLE_LIMIT      = 400000;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       cfg_we   = 1'b0;
	cfg_reg_t   cfg_idx  = CFG_NODE_ID;
	logic [7:0] cfg_data = 8'h00;

	etrb_in_if  in_ch ();
	etrb_out_if out_ch ();

	int unsigned mismatches;
	int unsigned awaiting;

	// Traffic shaping, written only by the stimulus process.
	int unsigned idle_pct      = 0;
	int unsigned stall_pct     = 0;
	int unsigned hold_requests = 0;
	logic [7:0]  recovered_now = RECOV_RST;

	// Owned by the result-side process.
	int unsigned holds_served = 0;
	int unsigned hold_left    = 0;

	int unsigned cycle_cnt = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	event_trace_ring_buffer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	trace_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// Result side: random stalls at the current rate, or a long hold-off when the
	// stimulus asks for one. The hold is counted here, cycle by cycle, so the
	// sender keeps offering beats and the buffer backs up into in_ch.ready.
	initial begin : result_side
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Bail out if the run hangs; the limit is far above the slowest legal run.
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offer one command beat after a random idle gap; return at the falling edge
	// after it was taken, leaving valid high so back-to-back beats stay back-to-back.
	task automatic send_cmd(input req_t c);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.action        <= c.action;
		in_ch.code          <= c.code;
		in_ch.prior_state   <= c.prior_state;
		in_ch.elapsed_time  <= c.elapsed_time;
		in_ch.arg_wide0     <= c.arg_wide0;
		in_ch.arg_wide1     <= c.arg_wide1;
		in_ch.in_low_byte   <= c.in_low_byte;
		in_ch.in_high_byte  <= c.in_high_byte;
		in_ch.out_low_byte  <= c.out_low_byte;
		in_ch.out_high_byte <= c.out_high_byte;
		in_ch.enable        <= c.enable;
		in_ch.now_ms        <= c.now_ms;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic drain(input int unsigned extra);
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_RECOVERED) recovered_now = val;
	endtask

	function automatic req_t quiet_cmd(input act_t a);
		req_t c;
		c        = '0;
		c.action = a;
		return c;
	endfunction

	// Wide arguments: full range, in range, or right at the saturation boundary.
	function automatic logic [31:0] wide_arg();
		case ($urandom_range(2))
		0:       return $urandom;
		1:       return $urandom_range(32'h0000_FFFF);
		default: return 32'h0000_FFFF + $urandom_range(1);
		endcase
	endfunction

	function automatic req_t random_cmd(input int unsigned push_pct);
		req_t        c;
		int unsigned pick;
		if ($urandom_range(3) == 0) c.code = recovered_now;
		else c.code = 8'($urandom_range(255));
		c.prior_state   = 8'($urandom_range(255));
		c.elapsed_time  = wide_arg();
		c.arg_wide0     = wide_arg();
		c.arg_wide1     = wide_arg();
		c.in_low_byte   = 8'($urandom_range(255));
		c.in_high_byte  = 8'($urandom_range(255));
		c.out_low_byte  = 8'($urandom_range(255));
		c.out_high_byte = 8'($urandom_range(255));
		c.enable        = ($urandom_range(3) != 0);
		c.now_ms        = $urandom;
		pick = $urandom_range(99);
		if ($urandom_range(99) < push_pct) c.action = act_t'($urandom_range(3));
		else if (pick < 55) c.action = ACT_READ;
		else if (pick < 88) c.action = ACT_POP;
		else if (pick < 97) c.action = ACT_RTSET;
		else c.action = ACT_CLEAR;   // keep rare so the ring gets a chance to wrap
		return c;
	endfunction

	initial begin : stimulus
		req_t c;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_READ;
		in_ch.code = '0;
		in_ch.prior_state = '0;
		in_ch.elapsed_time = '0;
		in_ch.arg_wide0 = '0;
		in_ch.arg_wide1 = '0;
		in_ch.in_low_byte = '0;
		in_ch.in_high_byte = '0;
		in_ch.out_low_byte = '0;
		in_ch.out_high_byte = '0;
		in_ch.enable = 1'b0;
		in_ch.now_ms = '0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed opening: register extremes first.
		write_reg(CFG_NODE_ID, 8'hFF);
		write_reg(CFG_RECOVERED, 8'h00);

		// Nothing logged yet: read and pop return no record; pop with realtime off.
		send_cmd(quiet_cmd(ACT_READ));
		send_cmd(quiet_cmd(ACT_POP));
		c = quiet_cmd(ACT_RTSET);
		c.enable = 1'b1;
		send_cmd(c);

		// One of each push kind, hitting saturation and byte packing edges.
		c = quiet_cmd(ACT_STATE);
		c.prior_state  = 8'hFF;
		c.elapsed_time = 32'hFFFF_FFFF;
		send_cmd(c);
		c = quiet_cmd(ACT_ACTION);
		c.code         = 8'hFF;
		c.elapsed_time = 32'h0000_FFFF;
		c.arg_wide1    = 32'hFFFF_1234;
		c.now_ms       = 32'hFFFF_FFFF;
		send_cmd(c);
		c = quiet_cmd(ACT_EVENT);               // recovered code: info level
		c.code      = 8'h00;
		c.arg_wide0 = 32'h0001_0000;
		send_cmd(c);
		c = quiet_cmd(ACT_EVENT);               // any other code: warning
		c.code      = 8'h7E;
		c.arg_wide0 = 32'h0000_FFFF;
		c.arg_wide1 = 32'hFFFF_FFFF;
		c.now_ms    = 32'h8000_0001;
		send_cmd(c);
		c = quiet_cmd(ACT_IO);
		c.in_low_byte   = 8'hFF;
		c.out_high_byte = 8'hFF;
		send_cmd(c);

		// Both cursors walk the same five records, then run dry.
		repeat (2) send_cmd(quiet_cmd(ACT_POP));
		repeat (6) send_cmd(quiet_cmd(ACT_READ));
		repeat (4) send_cmd(quiet_cmd(ACT_POP));

		// Clear keeps realtime on but empties it; then pop with realtime off.
		send_cmd(quiet_cmd(ACT_CLEAR));
		send_cmd(quiet_cmd(ACT_POP));
		send_cmd(quiet_cmd(ACT_RTSET));
		send_cmd(quiet_cmd(ACT_STATE));
		send_cmd(quiet_cmd(ACT_POP));
		send_cmd(quiet_cmd(ACT_READ));

		// Random phases: each opens with a push-heavy stretch that wraps the ring,
		// then shifts toward reads and pops so the cursors catch up.
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			drain(SETTLE_CYCLES);
			case (phase)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
				write_reg(CFG_NODE_ID, 8'h00);
				write_reg(CFG_RECOVERED, 8'hFF);
			end
			1: begin
				idle_pct  = 65;
				stall_pct = 0;
				write_reg(CFG_NODE_ID, 8'($urandom_range(255)));
				write_reg(CFG_RECOVERED, 8'($urandom_range(255)));
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 65;
				write_reg(CFG_NODE_ID, 8'hFF);
				write_reg(CFG_RECOVERED, 8'h01);
			end
			default: begin
				idle_pct  = 22;
				stall_pct = 22;
				write_reg(CFG_NODE_ID, 8'h5A);
				write_reg(CFG_RECOVERED, 8'h00);
			end
			endcase
			for (int unsigned n = 0; n < BEATS_PER_PHASE; n++) begin
				// Long result hold-off while commands keep coming at full rate.
				if (phase == 0 && n == 40) hold_requests++;
				// Sender pause: let every outstanding result come home mid-phase.
				if (phase == 2 && n == 75) drain(0);
				send_cmd(random_cmd((n < FILL_BEATS) ? 85 : 30));
			end
		end

		drain(SETTLE_CYCLES);
		if (mismatches == 0 && awaiting == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
